@@ rtl/gamepad_input_conditioner_core_macros.svh @@
// Assertion macros for the conditioner core.
`ifndef GAMEPAD_INPUT_CONDITIONER_CORE_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_CORE_MACROS_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define GIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gic: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define GIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gic: next-cycle check failed");
`else
`define GIC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GIC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/gic_pkg.sv @@
package gic_pkg;

  // Field widths
  localparam int KEYS_W = 18;
  localparam int RAW_W  = 9;
  localparam int BTN_W  = 16;
  localparam int STK_W  = 8;
  localparam int CFG_W  = 54;
  localparam int IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_DEAD_ZONE  = 3'd0,
    CFG_FULL_RANGE = 3'd1,
    CFG_CURVE_MODE = 3'd2,
    CFG_STEER_MODE = 3'd3,
    CFG_BINDS_A    = 3'd4,
    CFG_BINDS_B    = 3'd5,
    CFG_BINDS_C    = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [6:0]       DEAD_ZONE_RST  = 7'd16;
  localparam logic [7:0]       FULL_RANGE_RST = 8'd145;
  localparam logic [CFG_W-1:0] BINDS_A_RST    = 54'd2251799866638337;
  localparam logic [CFG_W-1:0] BINDS_B_RST    = 54'd1125899915231252;
  localparam logic [KEYS_W-1:0] BINDS_C_RST   = 18'd256;

  // Curve and steering modes
  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_SOFT   = 2'd1;
  localparam logic [1:0] STEER_OFF    = 2'd0;
  localparam logic [1:0] STEER_RAMP   = 2'd2;

  // Output scaling
  localparam int         FULL_OUT_INT  = 80;
  localparam int         RAMP_BASE_INT = 24;
  localparam logic [6:0] FULL_OUT      = 7'd80;
  localparam logic [6:0] RAMP_BASE     = 7'd24;
  localparam int         RAMP_STEPS_DEF = 8;

  // Divide by five through a reciprocal, exact below 1024
  localparam logic [7:0] RECIP5       = 8'd205;
  localparam int         RECIP5_SHIFT = 10;

  // Deadzone divider: 15-bit numerator, three quotient bits per step
  localparam int NUM_W     = 15;
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Key positions
  localparam int KEY_DU = 10;
  localparam int KEY_DD = 11;
  localparam int KEY_DL = 12;
  localparam int KEY_DR = 13;
  localparam int KEY_CL = 16;
  localparam int KEY_CR = 17;

  // Target button bits
  localparam logic [BTN_W-1:0] BTN_ACCEL = 16'h8000;
  localparam logic [BTN_W-1:0] BTN_BOOST = 16'h4000;
  localparam logic [BTN_W-1:0] BTN_SLIDE_L = 16'h2000;
  localparam logic [BTN_W-1:0] BTN_PAUSE = 16'h1000;
  localparam logic [BTN_W-1:0] BTN_DU    = 16'h0800;
  localparam logic [BTN_W-1:0] BTN_DD    = 16'h0400;
  localparam logic [BTN_W-1:0] BTN_DL    = 16'h0200;
  localparam logic [BTN_W-1:0] BTN_DR    = 16'h0100;
  localparam logic [BTN_W-1:0] BTN_SLIDE_R = 16'h0010;
  localparam logic [BTN_W-1:0] BTN_CAMERA = 16'h0008;
  localparam logic [BTN_W-1:0] BTN_BRAKE = 16'h0004;
  localparam logic [BTN_W-1:0] BTN_CL    = 16'h0002;
  localparam logic [BTN_W-1:0] BTN_CR    = 16'h0001;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch item, prime divider for x
    logic div_step;  // three divider iterations
    logic shape;     // saturate and form curve polynomial
    logic scale;     // reciprocal divide, sign, store axis
    logic commit;    // steer, update counters, load result
    logic sel_y;     // axis in work
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

@@ rtl/gic_if.sv @@
interface gic_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [gic_pkg::KEYS_W-1:0]       held_keys;
  logic signed [gic_pkg::RAW_W-1:0]        raw_x;
  logic signed [gic_pkg::RAW_W-1:0]        raw_y;

  modport source (output valid, held_keys, raw_x, raw_y, input ready);
  modport sink   (input valid, held_keys, raw_x, raw_y, output ready);
endinterface

interface gic_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [gic_pkg::BTN_W-1:0]        buttons;
  logic signed [gic_pkg::STK_W-1:0]        stick_x;
  logic signed [gic_pkg::STK_W-1:0]        stick_y;

  modport source (output valid, buttons, stick_x, stick_y, input ready);
  modport sink   (input valid, buttons, stick_x, stick_y, output ready);
endinterface

@@ rtl/gic_ctrl.sv @@
`include "gamepad_input_conditioner_core_macros.svh"

module gic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gic_pkg::cmd_t    cmd_o,
  input  gic_pkg::status_t status_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SHAPE = 5'b00100,
    S_SCALE = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   sel_y_q, sel_y_d;
  logic   out_valid_q, out_valid_d;
  logic   commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    sel_y_d = sel_y_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DIV;
          sel_y_d = 1'b0;
        end
      end
      S_DIV: begin
        if (status_i.div_last) state_d = S_SHAPE;
      end
      S_SHAPE: state_d = S_SCALE;
      S_SCALE: begin
        if (sel_y_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIV;
          sel_y_d = 1'b1;
        end
      end
      S_FIN: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.shape    = (state_q == S_SHAPE);
    cmd_o.scale    = (state_q == S_SCALE);
    cmd_o.commit   = commit;
    cmd_o.sel_y    = sel_y_q;
  end

  // Hold the result until taken; a commit always finds the register free.
  assign out_valid_d = commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_y_q     <= sel_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GIC_ASSERT_IMP(a_commit_free, clk_i, rst_ni, cmd_o.commit, (!out_valid_q || out_ready_i))
  `GIC_ASSERT_NXT(a_accept_starts_x, clk_i, rst_ni, (in_valid_i && in_ready_o), (state_q == S_DIV && !sel_y_q))
  `GIC_ASSERT_NXT(a_div_runs, clk_i, rst_ni, (state_q == S_DIV && !status_i.div_last), (state_q == S_DIV))
  `GIC_ASSERT_IMP(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_FIN))
  `GIC_ASSERT_NXT(a_y_follows_x, clk_i, rst_ni, (state_q == S_SCALE && !sel_y_q), (state_q == S_DIV && sel_y_q))

endmodule

@@ rtl/gic_datapath.sv @@
module gic_datapath #(
  parameter int RAMP_STEPS = gic_pkg::RAMP_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gic_pkg::cmd_t                      cmd_i,
  output gic_pkg::status_t                   status_o,
  input  logic [gic_pkg::KEYS_W-1:0]         held_keys_i,
  input  logic signed [gic_pkg::RAW_W-1:0]   raw_x_i,
  input  logic signed [gic_pkg::RAW_W-1:0]   raw_y_i,
  input  logic                               cfg_we_i,
  input  logic [gic_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [gic_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic [gic_pkg::BTN_W-1:0]          buttons_o,
  output logic signed [gic_pkg::STK_W-1:0]   stick_x_o,
  output logic signed [gic_pkg::STK_W-1:0]   stick_y_o
);

  localparam int CNT_W   = $clog2(RAMP_STEPS + 1);
  localparam int RampInc = (gic_pkg::FULL_OUT_INT - gic_pkg::RAMP_BASE_INT) / RAMP_STEPS;
  localparam int NW      = gic_pkg::NUM_W;
  localparam int KW      = gic_pkg::KEYS_W;

  // Configuration
  logic [6:0]    dz_q;
  logic [7:0]    fr_q;
  logic [1:0]    curve_q;
  logic [1:0]    steer_q;
  logic [gic_pkg::CFG_W-1:0] bind_a_q, bind_b_q;
  logic [KW-1:0] bind_c_q;

  // Item and axis state
  logic [KW-1:0]        keys_q;
  logic signed [8:0]    raw_y_q;
  logic                 neg_q, zero_q;
  logic [NW-1:0]        num_q, quo_q;
  logic [7:0]           rem_q;
  logic [gic_pkg::DCNT_W-1:0] dcnt_q;
  logic [6:0]           s_q;
  logic [13:0]          poly_q;
  logic signed [7:0]    ax_x_q, ax_y_q;
  logic [CNT_W-1:0]     cnt_x_q, cnt_y_q;
  logic [gic_pkg::BTN_W-1:0] buttons_q;
  logic signed [7:0]    stick_x_q, stick_y_q;

  // Divider set-up
  logic              init;
  logic signed [8:0] v_sel;
  logic [8:0]        mag, diff;
  logic [NW-1:0]     num_init;
  logic [7:0]        span;

  assign init  = cmd_i.capture || (cmd_i.scale && !cmd_i.sel_y);
  assign v_sel = cmd_i.capture ? raw_x_i : raw_y_q;
  assign mag   = v_sel[8] ? 9'(-v_sel) : 9'(v_sel);
  assign diff  = mag - {2'b00, dz_q};
  assign num_init = NW'({diff, 6'b0}) + NW'({diff, 4'b0});
  assign span  = (fr_q > {1'b0, dz_q}) ? (fr_q - {1'b0, dz_q}) : 8'd1;

  // Three restoring iterations per step
  logic [7:0]    rem_n;
  logic [NW-1:0] num_n, quo_n;
  logic [8:0]    trial;
  always_comb begin
    rem_n = rem_q;
    num_n = num_q;
    quo_n = quo_q;
    trial = '0;
    for (int i = 0; i < gic_pkg::DIV_BITS; i++) begin
      trial = {rem_n, num_n[NW-1]};
      num_n = {num_n[NW-2:0], 1'b0};
      if (trial >= {1'b0, span}) begin
        rem_n = 8'(trial - {1'b0, span});
        quo_n = {quo_n[NW-2:0], 1'b1};
      end else begin
        rem_n = trial[7:0];
        quo_n = {quo_n[NW-2:0], 1'b0};
      end
    end
  end

  assign status_o.div_last = (dcnt_q == gic_pkg::DCNT_W'(gic_pkg::DIV_STEPS - 1));

  // Saturate and form the curve polynomial
  logic [6:0]  s_sat;
  logic [13:0] sq, poly_n;
  assign s_sat = (quo_q > NW'(gic_pkg::FULL_OUT_INT)) ? gic_pkg::FULL_OUT : quo_q[6:0];
  assign sq    = {7'b0, s_sat} * {7'b0, s_sat};
  always_comb begin
    if (curve_q == gic_pkg::CURVE_SOFT) begin
      poly_n = 14'({s_sat, 6'b0}) + 14'({s_sat, 4'b0}) + sq + 14'(gic_pkg::FULL_OUT_INT);
    end else begin
      poly_n = sq + 14'(gic_pkg::FULL_OUT_INT / 2);
    end
  end

  // Divide by 160 or 80: shift, then multiply by the reciprocal of five
  logic [8:0]        x9;
  logic [16:0]       prod;
  logic [6:0]        mag_out;
  logic signed [7:0] ax_n;
  assign x9   = (curve_q == gic_pkg::CURVE_SOFT) ? poly_q[13:5] : poly_q[12:4];
  assign prod = x9 * gic_pkg::RECIP5;
  always_comb begin
    if (zero_q) begin
      mag_out = '0;
    end else if (curve_q == gic_pkg::CURVE_LINEAR) begin
      mag_out = s_q;
    end else begin
      mag_out = prod[gic_pkg::RECIP5_SHIFT +: 7];
    end
  end
  assign ax_n = neg_q ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});

  // Steering
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < CNT_W'(RAMP_STEPS)) ? c + 1'b1 : CNT_W'(RAMP_STEPS);
  endfunction

  function automatic logic signed [7:0] steer(input logic nz, input logic dneg,
                                              input logic [CNT_W-1:0] held,
                                              input logic [1:0] mode,
                                              input logic signed [7:0] analog);
    logic [6:0] m;
    logic [6:0] amag;
    m    = gic_pkg::FULL_OUT;
    amag = analog[7] ? 7'(-analog) : analog[6:0];
    if (mode == gic_pkg::STEER_RAMP) begin
      m = gic_pkg::RAMP_BASE + 7'(held * RampInc);
      if (m > gic_pkg::FULL_OUT) m = gic_pkg::FULL_OUT;
    end
    if (!nz || amag > m) return analog;
    return dneg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic             dx_nz, dy_nz;
  logic [CNT_W-1:0] cnt_x_n, cnt_y_n;
  logic [gic_pkg::BTN_W-1:0] btn_n;
  logic signed [7:0] sx_n, sy_n;

  assign dx_nz = keys_q[gic_pkg::KEY_DR] ^ keys_q[gic_pkg::KEY_DL];
  assign dy_nz = keys_q[gic_pkg::KEY_DU] ^ keys_q[gic_pkg::KEY_DD];

  always_comb begin
    if (steer_q == gic_pkg::STEER_OFF) begin
      cnt_x_n = '0;
      cnt_y_n = '0;
      sx_n    = ax_x_q;
      sy_n    = ax_y_q;
    end else begin
      cnt_x_n = dx_nz ? bump(cnt_x_q) : '0;
      cnt_y_n = dy_nz ? bump(cnt_y_q) : '0;
      sx_n    = steer(dx_nz, keys_q[gic_pkg::KEY_DL], cnt_x_n, steer_q, ax_x_q);
      sy_n    = steer(dy_nz, keys_q[gic_pkg::KEY_DD], cnt_y_n, steer_q, ax_y_q);
    end
  end

  always_comb begin
    btn_n = '0;
    if (|(keys_q & bind_a_q[0 +: KW]))    btn_n |= gic_pkg::BTN_ACCEL;
    if (|(keys_q & bind_a_q[KW +: KW]))   btn_n |= gic_pkg::BTN_BOOST;
    if (|(keys_q & bind_a_q[2*KW +: KW])) btn_n |= gic_pkg::BTN_BRAKE;
    if (|(keys_q & bind_b_q[0 +: KW]))    btn_n |= gic_pkg::BTN_SLIDE_L;
    if (|(keys_q & bind_b_q[KW +: KW]))   btn_n |= gic_pkg::BTN_SLIDE_R;
    if (|(keys_q & bind_b_q[2*KW +: KW])) btn_n |= gic_pkg::BTN_CAMERA;
    if (|(keys_q & bind_c_q))             btn_n |= gic_pkg::BTN_PAUSE;
    if (keys_q[gic_pkg::KEY_DU]) btn_n |= gic_pkg::BTN_DU;
    if (keys_q[gic_pkg::KEY_DD]) btn_n |= gic_pkg::BTN_DD;
    if (keys_q[gic_pkg::KEY_DL]) btn_n |= gic_pkg::BTN_DL;
    if (keys_q[gic_pkg::KEY_DR]) btn_n |= gic_pkg::BTN_DR;
    if (keys_q[gic_pkg::KEY_CL]) btn_n |= gic_pkg::BTN_CL;
    if (keys_q[gic_pkg::KEY_CR]) btn_n |= gic_pkg::BTN_CR;
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= gic_pkg::DEAD_ZONE_RST;
      fr_q     <= gic_pkg::FULL_RANGE_RST;
      curve_q  <= gic_pkg::CURVE_LINEAR;
      steer_q  <= gic_pkg::STEER_OFF;
      bind_a_q <= gic_pkg::BINDS_A_RST;
      bind_b_q <= gic_pkg::BINDS_B_RST;
      bind_c_q <= gic_pkg::BINDS_C_RST;
      dcnt_q   <= '0;
      cnt_x_q  <= '0;
      cnt_y_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (gic_pkg::cfg_idx_e'(cfg_idx_i))
          gic_pkg::CFG_DEAD_ZONE:  dz_q     <= cfg_wdata_i[6:0];
          gic_pkg::CFG_FULL_RANGE: fr_q     <= cfg_wdata_i[7:0];
          gic_pkg::CFG_CURVE_MODE: curve_q  <= cfg_wdata_i[1:0];
          gic_pkg::CFG_STEER_MODE: steer_q  <= cfg_wdata_i[1:0];
          gic_pkg::CFG_BINDS_A:    bind_a_q <= cfg_wdata_i;
          gic_pkg::CFG_BINDS_B:    bind_b_q <= cfg_wdata_i;
          gic_pkg::CFG_BINDS_C:    bind_c_q <= cfg_wdata_i[KW-1:0];
          default: ;
        endcase
      end
      if (init) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        cnt_x_q <= cnt_x_n;
        cnt_y_q <= cnt_y_n;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      keys_q  <= held_keys_i;
      raw_y_q <= raw_y_i;
    end
    if (init) begin
      neg_q  <= v_sel[8];
      zero_q <= (mag <= {2'b00, dz_q});
      num_q  <= num_init;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_n;
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
    if (cmd_i.shape) begin
      s_q    <= s_sat;
      poly_q <= poly_n;
    end
    if (cmd_i.scale) begin
      if (cmd_i.sel_y) ax_y_q <= ax_n;
      else             ax_x_q <= ax_n;
    end
    if (cmd_i.commit) begin
      buttons_q <= btn_n;
      stick_x_q <= sx_n;
      stick_y_q <= sy_n;
    end
  end

  assign buttons_o = buttons_q;
  assign stick_x_o = stick_x_q;
  assign stick_y_o = stick_y_q;

endmodule

@@ rtl/gamepad_input_conditioner_core.sv @@
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   held_keys[17:0], raw_x[8:0] s, raw_y[8:0] s
// out_o    out  valid/ready   buttons[15:0], stick_x[7:0] s, stick_y[7:0] s
// cfg      in   cfg_we_i      cfg_idx_i[2:0], cfg_wdata_i[53:0]
//
// An item runs from acceptance to a loaded result in order: an accept step,
// then per axis five divider steps of three quotient bits, a shape step and a
// scale step, then a commit step. The shared deadzone divider sets the rate.
// Reset restores the register defaults and clears both hold counters.
// A stalled output holds the result; the next item is taken meanwhile and
// waits in the commit cycle only if the previous result is still untaken.
module gamepad_input_conditioner_core #(
  parameter int RAMP_STEPS = gic_pkg::RAMP_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gic_in_if.sink                        in_i,
  gic_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [gic_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata_i
);

  gic_pkg::cmd_t    cmd;
  gic_pkg::status_t status;

  // Sequence the item: accept, divide, shape, scale per axis, then commit
  gic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold configuration, run the arithmetic and keep the result register
  gic_datapath #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .held_keys_i (in_i.held_keys),
    .raw_x_i     (in_i.raw_x),
    .raw_y_i     (in_i.raw_y),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .buttons_o   (out_o.buttons),
    .stick_x_o   (out_o.stick_x),
    .stick_y_o   (out_o.stick_y)
  );

endmodule
